### rtl/lsp_pkg.sv
// Shared types and codes for the looping sample player.
package lsp_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_SEEK  = 3'd1;
    localparam logic [2:0] REQ_PLAY  = 3'd2;
    localparam logic [2:0] REQ_PAUSE = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_TRACK_LENGTH    = 3'd0;
    localparam logic [2:0] CFG_SOURCE_CHANNELS = 3'd1;
    localparam logic [2:0] CFG_SPEED_RATIO     = 3'd2;
    localparam logic [2:0] CFG_LOOP_ENABLE     = 3'd3;
    localparam logic [2:0] CFG_LOOP_BEGIN      = 3'd4;
    localparam logic [2:0] CFG_LOOP_FINISH     = 3'd5;

    // Speed ratio limits, Q3.16 (0.25 and 4.0)
    localparam logic [18:0] RATIO_LO = 19'd16384;
    localparam logic [18:0] RATIO_HI = 19'd262144;

    // Playhead is a fixed 33-bit position
    localparam int PH_W = 33;

    // Result queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Command word handed from the front to the back
    typedef struct packed {
        logic        valid;
        logic        frame;
        logic        mono;
        logic        playing;
        logic [16:0] whole;
    } lsp_cmd_t;

    // Result word as delivered on the output ports
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               frame_valid;
        logic               is_playing;
        logic [16:0]        playhead_whole;
    } lsp_res_t;

endpackage

### rtl/lsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/lsp_front.sv
// Front end: configuration, playhead and play state, memory access issue.
module lsp_front
    import lsp_pkg::*;
#(
    parameter int MAX_FRAMES = 65536,
    parameter int FRAC_BITS  = 16,
    parameter int AW         = $clog2(MAX_FRAMES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    input  logic               full,
    input  logic [2:0]         req_type,
    input  logic [15:0]        sample_index,
    input  logic               sample_channel,
    input  logic signed [15:0] sample_value,
    input  logic [31:0]        seek_target,
    output logic               wr_en0,
    output logic               wr_en1,
    output logic [AW-1:0]      wr_addr,
    output logic [15:0]        wr_data,
    output logic [AW-1:0]      rd_addr,
    output lsp_cmd_t           cmd_reg
);

    localparam logic [24:0] MAX_LEN = 25'(MAX_FRAMES);

    logic [16:0]     track_length_reg;
    logic [1:0]      source_channels_reg;
    logic [18:0]     speed_ratio_reg;
    logic            loop_enable_reg;
    logic [31:0]     loop_begin_reg;
    logic [31:0]     loop_finish_reg;
    logic [PH_W-1:0] playhead_reg;
    logic [PH_W-1:0] playhead_next;
    logic            playing_reg;
    logic            playing_next;
    lsp_cmd_t        cmd_next;

    logic            accept;
    logic [24:0]     len;
    logic [18:0]     ratio;
    logic [PH_W-1:0] pos_loop;
    logic [PH_W-1:0] whole_full;
    logic [PH_W-1:0] next_whole;
    logic            in_range;
    logic [PH_W:0]   sum;
    logic [PH_W-1:0] pos_adv;
    logic [41:0]     seek_top;
    logic [PH_W-1:0] seek_pos;
    logic            frame;
    logic            wr_ok;

    assign accept = push && !full;

    // Effective length, ratio and loop-adjusted position
    always_comb
    begin
        len = ({8'd0, track_length_reg} > MAX_LEN) ? MAX_LEN : {8'd0, track_length_reg};
        if (speed_ratio_reg < RATIO_LO)
        begin
            ratio = RATIO_LO;
        end
        else if (speed_ratio_reg > RATIO_HI)
        begin
            ratio = RATIO_HI;
        end
        else
        begin
            ratio = speed_ratio_reg;
        end
        if (loop_enable_reg && (playhead_reg >= {1'b0, loop_finish_reg}))
        begin
            pos_loop = {1'b0, loop_begin_reg};
        end
        else
        begin
            pos_loop = playhead_reg;
        end
        whole_full = pos_loop >> FRAC_BITS;
        in_range   = whole_full < {8'd0, len};
        sum        = {1'b0, pos_loop} + (PH_W + 1)'(ratio);
        pos_adv    = sum[PH_W] ? {PH_W{1'b1}} : sum[PH_W-1:0];
        seek_top   = 42'(len - 25'd1) << FRAC_BITS;
        seek_pos   = ({10'd0, seek_target} > seek_top) ? seek_top[PH_W-1:0]
                                                       : {1'b0, seek_target};
        wr_ok      = {9'd0, sample_index} < MAX_LEN;
    end

    // Decode the request and form next state
    always_comb
    begin
        playhead_next = playhead_reg;
        playing_next  = playing_reg;
        frame         = 1'b0;
        wr_en0        = 1'b0;
        wr_en1        = 1'b0;
        case (req_type)
            REQ_WRITE:
            begin
                wr_en0 = accept && wr_ok && !sample_channel;
                wr_en1 = accept && wr_ok && sample_channel;
            end
            REQ_SEEK:
            begin
                playhead_next = (len == 25'd0) ? {PH_W{1'b0}} : seek_pos;
            end
            REQ_PLAY:
            begin
                if (track_length_reg != 17'd0)
                begin
                    playing_next = 1'b1;
                end
            end
            REQ_PAUSE:
            begin
                playing_next = 1'b0;
            end
            REQ_TICK:
            begin
                if ((track_length_reg != 17'd0) && playing_reg)
                begin
                    if (in_range)
                    begin
                        frame         = 1'b1;
                        playhead_next = pos_adv;
                    end
                    else
                    begin
                        playing_next  = 1'b0;
                        playhead_next = pos_loop;
                    end
                end
            end
            default:
            begin
                playhead_next = playhead_reg;
            end
        endcase
        next_whole       = playhead_next >> FRAC_BITS;
        cmd_next.valid   = accept;
        cmd_next.frame   = frame;
        cmd_next.mono    = source_channels_reg <= 2'd1;
        cmd_next.playing = playing_next;
        cmd_next.whole   = next_whole[16:0];
    end

    assign wr_addr = AW'(sample_index);
    assign wr_data = sample_value;
    assign rd_addr = whole_full[AW-1:0];

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_length_reg    <= 17'd0;
            source_channels_reg <= 2'd2;
            speed_ratio_reg     <= 19'd65536;
            loop_enable_reg     <= 1'b0;
            loop_begin_reg      <= 32'd0;
            loop_finish_reg     <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TRACK_LENGTH:    track_length_reg    <= cfg_data[16:0];
                CFG_SOURCE_CHANNELS: source_channels_reg <= cfg_data[1:0];
                CFG_SPEED_RATIO:     speed_ratio_reg     <= cfg_data[18:0];
                CFG_LOOP_ENABLE:     loop_enable_reg     <= cfg_data[0];
                CFG_LOOP_BEGIN:      loop_begin_reg      <= cfg_data;
                CFG_LOOP_FINISH:     loop_finish_reg     <= cfg_data;
                default:             loop_enable_reg     <= loop_enable_reg;
            endcase
        end
    end

    // Advance playhead and play state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playhead_reg <= {PH_W{1'b0}};
            playing_reg  <= 1'b0;
            cmd_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                playhead_reg <= playhead_next;
                playing_reg  <= playing_next;
            end
            cmd_reg <= cmd_next;
        end
    end

    // Only one sample store is written per word
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({wr_en0, wr_en1}))
        else $error("both channel stores written at once");

    // A frame is only issued while playing
    a_frame_playing: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg.valid && cmd_reg.frame) |-> cmd_reg.playing)
        else $error("frame issued while stopped");

    // A tick while stopped leaves the playhead alone
    a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_TICK) && !playing_reg) |=> $stable(playhead_reg))
        else $error("playhead moved on a stopped tick");

endmodule

### rtl/lsp_back.sv
// Back end: frame assembly from store read data and the result queue.
module lsp_back
    import lsp_pkg::*;
#(
    parameter int OUT_CHANNELS = 2
) (
    input  logic     clk,
    input  logic     rst_n,
    input  lsp_cmd_t cmd,
    input  logic [15:0] rd0,
    input  logic [15:0] rd1,
    input  logic     pop,
    output logic     full,
    output logic     empty,
    output lsp_res_t res
);

    lsp_res_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    lsp_res_t            word;
    logic                do_pop;

    // Build the result word; silence when no frame
    always_comb
    begin
        word.frame_valid    = cmd.frame;
        word.is_playing     = cmd.playing;
        word.playhead_whole = cmd.whole;
        word.left           = cmd.frame ? rd0 : 16'd0;
        if (cmd.frame && (OUT_CHANNELS >= 2))
        begin
            word.right = cmd.mono ? rd0 : rd1;
        end
        else
        begin
            word.right = 16'd0;
        end
    end

    assign empty  = count_reg == '0;
    assign do_pop = pop && !empty;
    // Count the word in flight from the front so it always has a slot
    assign full   = (count_reg + QCNT_W'(cmd.valid)) >= QCNT_W'(QUEUE_DEPTH);
    assign res    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + QCNT_W'(cmd.valid) - QCNT_W'(do_pop);
    end

    // Store incoming words
    always_ff @(posedge clk)
    begin
        if (cmd.valid)
        begin
            entry_reg[wr_ptr_reg] <= word;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    // Count tracks pushes and pops
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("result queue count slip");

endmodule

### rtl/looping_sample_player.sv
// Top level of the looping sample player.
// Path: an accepted word is registered as a command word in the front, then written into the result queue.
// Throughput: one word per cycle while full is low; the playhead add and one store read per tick
// set that figure, and a four-entry result queue absorbs output stalls.
// Reset: rst_n clears playhead, play state and queue and sets the registers to
// their defaults at once; the sample store is not cleared and holds nothing valid until written.
module looping_sample_player
    import lsp_pkg::*;
#(
    parameter int MAX_FRAMES   = 65536,
    parameter int OUT_CHANNELS = 2,
    parameter int FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         req_type,
    input  logic [15:0]        sample_index,
    input  logic               sample_channel,
    input  logic signed [15:0] sample_value,
    input  logic [31:0]        seek_target,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               frame_valid,
    output logic               is_playing,
    output logic [16:0]        playhead_whole
);

    localparam int AW = $clog2(MAX_FRAMES);

    logic          wr_en0;
    logic          wr_en1;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd0;
    logic [15:0]   rd1;
    lsp_cmd_t      cmd;
    lsp_res_t      res;

    lsp_front #(
        .MAX_FRAMES(MAX_FRAMES),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .sample_index  (sample_index),
        .sample_channel(sample_channel),
        .sample_value  (sample_value),
        .seek_target   (seek_target),
        .wr_en0        (wr_en0),
        .wr_en1        (wr_en1),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .cmd_reg       (cmd)
    );

    // Channel 0 sample store
    lsp_ram #(
        .WIDTH(16),
        .DEPTH(MAX_FRAMES)
    ) u_ram0 (
        .clk  (clk),
        .we   (wr_en0),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd0)
    );

    // Channel 1 sample store
    lsp_ram #(
        .WIDTH(16),
        .DEPTH(MAX_FRAMES)
    ) u_ram1 (
        .clk  (clk),
        .we   (wr_en1),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd1)
    );

    lsp_back #(
        .OUT_CHANNELS(OUT_CHANNELS)
    ) u_back (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .rd0  (rd0),
        .rd1  (rd1),
        .pop  (pop),
        .full (full),
        .empty(empty),
        .res  (res)
    );

    assign left_out       = res.left;
    assign right_out      = res.right;
    assign frame_valid    = res.frame_valid;
    assign is_playing     = res.is_playing;
    assign playhead_whole = res.playhead_whole;

endmodule

### tb/looping_sample_player_tb.sv
// Testbench for the looping sample player: queue-fed driver, result predictor and checker.
module looping_sample_player_tb;
    import lsp_pkg::*;

    localparam int MAX_FRAMES  = 65536;
    localparam int FRAC        = 16;
    // frames of both channels loaded up front; playback never reads past them
    localparam int FILL_FRAMES = 128;
    localparam longint unsigned PH_MAX = 64'h1_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         req;
        logic [15:0]        idx;
        logic               ch;
        logic signed [15:0] val;
        logic [31:0]        tgt;
    } req_word_t;

    logic               clk;
    logic               rst_n          = 1'b0;
    logic               cfg_write      = 1'b0;
    logic [2:0]         cfg_index      = CFG_TRACK_LENGTH;
    logic [31:0]        cfg_data       = '0;
    logic               push           = 1'b0;
    logic               full;
    logic [2:0]         req_type       = REQ_WRITE;
    logic [15:0]        sample_index   = '0;
    logic               sample_channel = 1'b0;
    logic signed [15:0] sample_value   = '0;
    logic [31:0]        seek_target    = '0;
    logic               empty;
    logic               pop            = 1'b0;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               frame_valid;
    logic               is_playing;
    logic [16:0]        playhead_whole;

    // stimulus and checking bookkeeping
    req_word_t req_backlog[$];
    lsp_res_t  result_due[$];
    int        mismatches   = 0;
    int        words_seen   = 0;
    int        send_gap_pct = 0;
    int        recv_gap_pct = 0;
    logic      hold_rx      = 1'b0;

    // predictor state and register copies
    logic [15:0] pcm_mem [0:1][0:MAX_FRAMES-1];
    logic [32:0] head_pos  = '0;
    logic        live      = 1'b0;
    logic [16:0] trk_len   = '0;
    logic [1:0]  src_ch    = 2'd2;
    logic [18:0] ratio_reg = 19'd65536;
    logic        loop_on   = 1'b0;
    logic [31:0] loop_lo   = '0;
    logic [31:0] loop_hi   = '0;

    looping_sample_player dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .sample_index   (sample_index),
        .sample_channel (sample_channel),
        .sample_value   (sample_value),
        .seek_target    (seek_target),
        .empty          (empty),
        .pop            (pop),
        .left_out       (left_out),
        .right_out      (right_out),
        .frame_valid    (frame_valid),
        .is_playing     (is_playing),
        .playhead_whole (playhead_whole)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one request word to the predictor and return the word it should produce
    function automatic lsp_res_t play_request(input req_word_t w);
        lsp_res_t          r;
        longint unsigned   lenv;
        longint unsigned   pos;
        longint unsigned   whole;
        longint unsigned   top;
        longint unsigned   inc;
        int                nch;
        r = '0;
        lenv = (trk_len > MAX_FRAMES) ? MAX_FRAMES : trk_len;
        case (w.req)
            REQ_WRITE:
            begin
                pcm_mem[w.ch][w.idx] = w.val;
            end
            REQ_SEEK:
            begin
                if (lenv == 0)
                    head_pos = '0;
                else
                begin
                    top = (lenv - 1) << FRAC;
                    head_pos = 33'((w.tgt > top) ? top : w.tgt);
                end
            end
            REQ_PLAY:
            begin
                if (trk_len != 0)
                    live = 1'b1;
            end
            REQ_PAUSE:
            begin
                live = 1'b0;
            end
            REQ_TICK:
            begin
                if (trk_len != 0 && live)
                begin
                    pos = head_pos;
                    // wrap first, then check for the end of the track
                    if (loop_on && pos >= loop_hi)
                        pos = loop_lo;
                    whole = pos >> FRAC;
                    if (whole >= lenv)
                        live = 1'b0;
                    else
                    begin
                        nch = (src_ch == 2'd0) ? 1 : (src_ch == 2'd3) ? 2 : int'(src_ch);
                        inc = (ratio_reg < RATIO_LO) ? RATIO_LO :
                              (ratio_reg > RATIO_HI) ? RATIO_HI : ratio_reg;
                        r.left = pcm_mem[0][whole[15:0]];
                        r.right = pcm_mem[nch == 2][whole[15:0]];
                        r.frame_valid = 1'b1;
                        pos = (PH_MAX - pos < inc) ? PH_MAX : pos + inc;
                    end
                    head_pos = pos[32:0];
                end
            end
            default:
            begin
            end
        endcase
        r.is_playing = live;
        r.playhead_whole = 17'(head_pos >> FRAC);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 40)
            $display("MISMATCH at word %0d: %s", words_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [16:0] got,
                               input logic [16:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Feed request words from the backlog; predict each one as it is taken
    always @(posedge clk)
    begin : word_feed
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                result_due.push_back(play_request(req_backlog.pop_front()));
            // hold a stalled word, else offer the next one or idle
            if (!(push && full))
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    push           <= 1'b1;
                    req_type       <= req_backlog[0].req;
                    sample_index   <= req_backlog[0].idx;
                    sample_channel <= req_backlog[0].ch;
                    sample_value   <= req_backlog[0].val;
                    seek_target    <= req_backlog[0].tgt;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Take result words and compare them with the oldest prediction
    always @(posedge clk)
    begin : result_check
        lsp_res_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (result_due.size() == 0)
                    flag_mismatch("result word with none expected");
                else
                begin
                    want = result_due.pop_front();
                    check_field("left_out", left_out, want.left);
                    check_field("right_out", right_out, want.right);
                    check_field("frame_valid", frame_valid, want.frame_valid);
                    check_field("is_playing", is_playing, want.is_playing);
                    check_field("playhead_whole", playhead_whole, want.playhead_whole);
                end
                words_seen++;
            end
            pop <= !hold_rx && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Stall the result side for a long stretch so the input backs up
    initial
    begin : rx_hold_off
        wait (words_seen >= 100);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (150) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin : watchdog
        #(8 * 600000);
        $display("looping_sample_player_tb: errors");
        $finish;
    end

    task automatic add_item(input logic [2:0] req, input logic [15:0] idx, input logic ch,
                            input logic [15:0] val, input logic [31:0] tgt);
        req_word_t w;
        w.req = req;
        w.idx = idx;
        w.ch  = ch;
        w.val = val;
        w.tgt = tgt;
        req_backlog.push_back(w);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TRACK_LENGTH:    trk_len   = val[16:0];
            CFG_SOURCE_CHANNELS: src_ch    = val[1:0];
            CFG_SPEED_RATIO:     ratio_reg = val[18:0];
            CFG_LOOP_ENABLE:     loop_on   = val[0];
            CFG_LOOP_BEGIN:      loop_lo   = val;
            CFG_LOOP_FINISH:     loop_hi   = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic program_regs(input logic [16:0] len, input logic [1:0] ch,
                                input logic [18:0] ratio, input logic lp,
                                input logic [31:0] lo, input logic [31:0] hi);
        write_reg(CFG_TRACK_LENGTH, len);
        write_reg(CFG_SOURCE_CHANNELS, ch);
        write_reg(CFG_SPEED_RATIO, ratio);
        write_reg(CFG_LOOP_ENABLE, lp);
        write_reg(CFG_LOOP_BEGIN, lo);
        write_reg(CFG_LOOP_FINISH, hi);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait until every word is taken and every prediction checked
    task automatic wait_idle();
        while (req_backlog.size() != 0 || result_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_target(input longint unsigned lenv);
        case ($urandom_range(4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return (lenv == 0) ? $urandom : $urandom_range(32'((lenv << FRAC) - 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_loop_pos();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(FILL_FRAMES << 17);
    endfunction

    // Mostly seek/play/tick runs with random content, plus writes and noise
    task automatic fill_random(input int n);
        int              made;
        int              k;
        int              j;
        int              pick;
        longint unsigned lenv;
        made = 0;
        lenv = (trk_len > MAX_FRAMES) ? MAX_FRAMES : trk_len;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // place, start, then a run of frames
                if ($urandom_range(1))
                begin
                    add_item(REQ_SEEK, $urandom, $urandom, $urandom, pick_target(lenv));
                    made++;
                end
                add_item(REQ_PLAY, $urandom, $urandom, $urandom, $urandom);
                k = $urandom_range(1, 12);
                for (j = 0; j < k; j++)
                    add_item(REQ_TICK, $urandom, $urandom, $urandom, $urandom);
                made += k + 1;
            end
            else if (pick < 75)
            begin
                // overwrite samples, half of them inside the played region
                k = $urandom_range(1, 4);
                for (j = 0; j < k; j++)
                    add_item(REQ_WRITE,
                             $urandom_range(1) ? $urandom_range(FILL_FRAMES - 1) : $urandom,
                             $urandom, $urandom, $urandom);
                made += k;
            end
            else if (pick < 85)
            begin
                add_item(REQ_SEEK, $urandom, $urandom, $urandom, pick_target(lenv));
                k = $urandom_range(1, 3);
                for (j = 0; j < k; j++)
                    add_item(REQ_TICK, $urandom, $urandom, $urandom, $urandom);
                made += k + 1;
            end
            else if (pick < 95)
            begin
                add_item(REQ_PAUSE, $urandom, $urandom, $urandom, $urandom);
                k = $urandom_range(0, 2);
                for (j = 0; j < k; j++)
                    add_item(REQ_TICK, $urandom, $urandom, $urandom, $urandom);
                add_item(REQ_PLAY, $urandom, $urandom, $urandom, $urandom);
                made += k + 2;
            end
            else
            begin
                add_item(REQ_TICK + 3'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                         $urandom);
                made++;
            end
        end
    endtask

    initial
    begin : stimulus
        int          i;
        int          ph;
        logic [18:0] rnd_ratio;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_gap_pct = 36;
        recv_gap_pct = 49;

        // nothing loaded: play ignored, tick silent, seek lands on zero
        add_item(REQ_PLAY, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        add_item(REQ_SEEK, 0, 0, 0, 32'hFFFF_FFFF);
        // load both channels of the region that playback may read
        for (i = 0; i < FILL_FRAMES; i++)
        begin
            add_item(REQ_WRITE, i, 1'b0, $urandom, 0);
            add_item(REQ_WRITE, i, 1'b1, $urandom, 0);
        end
        wait_idle();

        program_regs(FILL_FRAMES, 2'd2, 19'd65536, 1'b0, 32'h0, 32'h0);
        add_item(REQ_SEEK, 0, 0, 0, 32'h0);
        add_item(REQ_PLAY, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        // seek past the end clamps to the last frame, then run off the end
        add_item(REQ_SEEK, 0, 0, 0, 32'hFFFF_FFFF);
        add_item(REQ_TICK, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        add_item(REQ_PLAY, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        // fractional seek, then pause stops frames
        add_item(REQ_SEEK, 0, 0, 0, 32'h0003_8000);
        add_item(REQ_PLAY, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        add_item(REQ_PAUSE, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        // extreme writes, then play the rewritten first frame
        add_item(REQ_WRITE, 16'hFFFF, 1'b1, 16'h7FFF, 32'hFFFF_FFFF);
        add_item(REQ_WRITE, 16'h0000, 1'b0, 16'h8000, 32'h0);
        add_item(REQ_SEEK, 0, 0, 0, 32'h0);
        add_item(REQ_PLAY, 0, 0, 0, 0);
        add_item(REQ_TICK, 0, 0, 0, 0);
        // unknown request codes change nothing
        add_item(REQ_TICK + 3'd1, 0, 0, 0, 0);
        add_item(REQ_TICK + 3'd2, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        add_item(REQ_TICK + 3'd3, 0, 0, 0, 0);
        fill_random(130);
        wait_idle();

        // one frame, mono, slowest ratio, loop end at zero: always wrap
        program_regs(17'd1, 2'd1, 19'd0, 1'b1, 32'h0, 32'h0);
        fill_random(130);
        wait_idle();

        // channel count clamps to two, ratio clamps to 4.0, ordinary loop
        program_regs(17'd100, 2'd3, 19'h7FFFF, 1'b1, 32'h000A_8000, 32'h0028_0000);
        fill_random(130);
        wait_idle();

        send_gap_pct = 49;
        recv_gap_pct = 36;
        // full-size track kept inside the loaded region by the loop
        program_regs(17'd65536, 2'd2, 19'd262144, 1'b1, 32'h0005_0000, 32'h007F_FFFF);
        fill_random(130);
        wait_idle();

        // oversized length, zero channels, loop end below loop start
        program_regs(17'h1FFFF, 2'd0, 19'd16384, 1'b1, 32'h0064_0000, 32'h0014_0000);
        fill_random(130);
        wait_idle();

        // ratio just under the floor, loop points at the top of the range
        program_regs(FILL_FRAMES, 2'd2, 19'd16383, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        fill_random(130);
        wait_idle();

        // loop start beyond the track ends playback on every wrap
        program_regs(17'd50, 2'd2, 19'd70000, 1'b1, 32'h00C8_0000, 32'h001E_0000);
        fill_random(130);
        wait_idle();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        // unload the track
        program_regs(17'd0, 2'd3, 19'd100000, 1'b0, 32'h0, 32'hFFFF_FFFF);
        fill_random(130);
        wait_idle();

        // random settings; long tracks always loop inside the loaded region
        for (ph = 0; ph < 5; ph++)
        begin
            rnd_ratio = ($urandom_range(3) == 0) ? 19'($urandom_range(19'h7FFFF)) :
                        19'($urandom_range(RATIO_LO, RATIO_HI));
            if ($urandom_range(3) == 0)
                program_regs($urandom_range(FILL_FRAMES + 1, 17'h1FFFF), $urandom_range(3),
                             rnd_ratio, 1'b1, $urandom_range((FILL_FRAMES << FRAC) - 1),
                             $urandom_range(FILL_FRAMES << FRAC));
            else
                program_regs($urandom_range(FILL_FRAMES), $urandom_range(3), rnd_ratio,
                             $urandom_range(1), pick_loop_pos(), pick_loop_pos());
            fill_random(60);
            wait_idle();
        end

        if (mismatches == 0)
            $display("looping_sample_player_tb: clean");
        else
            $display("looping_sample_player_tb: errors");
        $finish;
    end

endmodule
